// File: sv/srd_pkg.sv
`default_nettype none
package srd_pkg;

  // Record geometry
  localparam int unsigned BASE_STRIDE = 3;
  localparam int unsigned WIDE_EXTRA  = 2;
  localparam int unsigned ROT_EXTRA   = 4;
  localparam int unsigned FIELD_BYTES = 8;  // record bytes after the shape tag
  localparam logic [7:0]  BYTE_MASK   = 8'hFF;

  localparam int unsigned POS_W = 4;

  // Configuration port
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam logic [7:0]  CAPACITY_RESET = 8'd255;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RECORD_FORMAT   = 2'd0,
    REG_OUTPUT_CAPACITY = 2'd1
  } cfg_reg_t;

  // Front-to-back queue
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic       wide;
    logic       rot;
    logic [7:0] capacity;
  } srd_cfg_t;

  // One classified result waiting for formatting
  typedef struct packed {
    logic                      rec_valid;
    logic                      wide;
    logic                      rot;
    logic [7:0]                shape_tag;
    logic [8*FIELD_BYTES-1:0]  field;
    logic [7:0]                index;
    logic                      done;
    logic [7:0]                decoded;
  } srd_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } srd_q_stat_t;

  function automatic logic [15:0] sext8(input logic [7:0] b);
    sext8 = {{8{b[7]}}, b};
  endfunction

endpackage
`default_nettype wire

// File: sv/srd_if.sv
`default_nettype none
interface srd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;
  logic [7:0] record_count;

  modport source (output valid, data_byte, first_byte, last_byte, record_count,
                  input ready);
  modport sink   (input valid, data_byte, first_byte, last_byte, record_count,
                  output ready);
endinterface

interface srd_out_if;
  logic               valid;
  logic               ready;
  logic               record_valid;
  logic [7:0]         shape_tag;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [15:0]        angle;
  logic signed [15:0] angular_rate;
  logic [7:0]         record_index;
  logic               message_done;
  logic [7:0]         records_decoded;

  modport source (output valid, record_valid, shape_tag, pos_x, pos_y, angle,
                  angular_rate, record_index, message_done, records_decoded,
                  input ready);
  modport sink   (input valid, record_valid, shape_tag, pos_x, pos_y, angle,
                  angular_rate, record_index, message_done, records_decoded,
                  output ready);
endinterface

interface srd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] reg_index;
  logic [7:0] reg_data;

  modport source (output valid, reg_index, reg_data, input ready);
  modport sink   (input valid, reg_index, reg_data, output ready);
endinterface
`default_nettype wire

// File: sv/srd_front.sv
`default_nettype none
module srd_front
  import srd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire srd_cfg_t   cfg,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       first_byte,
  input  wire logic       last_byte,
  input  wire logic [7:0] record_count,
  output logic            push,
  output srd_entry_t      entry
);

  logic [POS_W-1:0]         byte_position;
  logic [7:0]               records_emitted;
  logic [7:0]               record_limit;
  logic [8*FIELD_BYTES-1:0] field_bytes;
  logic [7:0]               held_shape_tag;

  logic [POS_W-1:0]         pos_eff;
  logic [7:0]               emitted_eff;
  logic [7:0]               limit_eff;
  logic [POS_W-1:0]         stride;
  logic [8*FIELD_BYTES-1:0] field_next;
  logic [7:0]               held_next;
  logic                     complete;
  logic                     emit;
  logic [7:0]               emitted_new;

  always_comb begin
    stride = POS_W'(BASE_STRIDE)
           + (cfg.wide ? POS_W'(WIDE_EXTRA) : '0)
           + (cfg.rot  ? POS_W'(ROT_EXTRA)  : '0);

    // first byte restarts the message before the byte is placed
    pos_eff     = first_byte ? '0 : byte_position;
    emitted_eff = first_byte ? '0 : records_emitted;
    limit_eff   = first_byte ? ((record_count < cfg.capacity) ? record_count : cfg.capacity)
                             : record_limit;

    held_next  = held_shape_tag;
    field_next = field_bytes;
    if (pos_eff == '0) begin
      held_next  = data_byte;
      field_next = '0;
    end else begin
      for (int k = 0; k < FIELD_BYTES; k++) begin
        if (pos_eff == POS_W'(k + 1)) begin
          field_next[8*k +: 8] = data_byte;
        end
      end
    end

    complete    = ({1'b0, pos_eff} + 1'b1) >= {1'b0, stride};
    emit        = complete && (emitted_eff < limit_eff);
    emitted_new = emitted_eff + {7'd0, emit};

    entry.rec_valid = emit;
    entry.wide      = cfg.wide;
    entry.rot       = cfg.rot;
    entry.shape_tag = held_next;
    entry.field     = field_next;
    entry.index     = emitted_eff;
    entry.done      = last_byte;
    entry.decoded   = last_byte ? emitted_new : '0;

    push = accept && (emit || last_byte);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      records_emitted <= '0;
      record_limit    <= '0;
    end else if (accept) begin
      if (last_byte) begin
        byte_position   <= '0;
        records_emitted <= '0;
        record_limit    <= '0;
      end else begin
        byte_position   <= complete ? '0 : pos_eff + 1'b1;
        records_emitted <= emitted_new;
        record_limit    <= limit_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      field_bytes    <= field_next;
      held_shape_tag <= held_next;
    end
  end

endmodule
`default_nettype wire

// File: sv/srd_queue.sv
`default_nettype none
module srd_queue
  import srd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire srd_entry_t push_data,
  input  wire logic       pop,
  output srd_entry_t      head,
  output srd_q_stat_t     stat
);

  srd_entry_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push;
  logic               do_pop;

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    bump = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    stat.empty = (count == '0);
    stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
    do_push    = push && !stat.full;
    do_pop     = pop && !stat.empty;
    head       = slots[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= bump(wr_ptr);
      if (do_pop)  rd_ptr <= bump(rd_ptr);
      count <= count + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule
`default_nettype wire

// File: sv/srd_back.sv
`default_nettype none
module srd_back
  import srd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire srd_entry_t   head,
  input  wire srd_q_stat_t  q_stat,
  output logic              pop,
  srd_out_if.source         records
);

  logic        take;
  logic [15:0] x_f, y_f, ang_f, rate_f;

  always_comb begin
    if (head.wide) begin
      x_f = head.field[15:0];
      y_f = head.field[31:16];
    end else begin
      x_f = sext8(head.field[7:0]);
      y_f = sext8(head.field[15:8]);
    end
    // angle and rate sit right after y
    if (!head.rot) begin
      ang_f  = '0;
      rate_f = '0;
    end else if (head.wide) begin
      ang_f  = head.field[47:32];
      rate_f = head.field[63:48];
    end else begin
      ang_f  = head.field[31:16];
      rate_f = head.field[47:32];
    end

    take = !q_stat.empty && (!records.valid || records.ready);
    pop  = take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      records.valid <= 1'b0;
    end else if (take) begin
      records.valid <= 1'b1;
    end else if (records.ready) begin
      records.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      records.record_valid    <= head.rec_valid;
      records.shape_tag       <= head.rec_valid ? head.shape_tag : '0;
      records.pos_x           <= head.rec_valid ? x_f : '0;
      records.pos_y           <= head.rec_valid ? y_f : '0;
      records.angle           <= head.rec_valid ? ang_f : '0;
      records.angular_rate    <= head.rec_valid ? rate_f : '0;
      records.record_index    <= head.rec_valid ? head.index : '0;
      records.message_done    <= head.done;
      records.records_decoded <= head.decoded;
    end
  end

endmodule
`default_nettype wire

// File: sv/shape_record_deframer.sv
`default_nettype none
// Shape record deframer. Payload bytes enter on "payload", one item per byte,
// and are cut into records of 3, 5, 7 or 9 bytes according to record_format
// (bit0: 16-bit little-endian x/y instead of sign-extended 8-bit, bit1: angle
// and rate follow y). The first byte of a message latches
// min(record_count, output_capacity) as the record limit; records past that
// limit, and a trailing partial record, are dropped. One item leaves on
// "records" for every emitted record and for every last byte; the last-byte
// item carries message_done and the number of records emitted. Throughput is
// one byte per clock while the queue is not full: the front end does all
// per-byte bookkeeping combinationally and hands finished records to a
// 2-entry queue; the back end formats the head of the queue into the output
// register, so a result is registered in a queue slot and then in the output
// register before it is presented. payload.ready drops only while the queue
// is full, i.e. while the downstream side keeps records.ready low.
// Configuration writes are always taken (cfg.ready is tied high); the format
// register is sampled per byte.
module shape_record_deframer
  import srd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  srd_in_if.sink     payload,
  srd_out_if.source  records,
  srd_cfg_if.sink    cfg
);

  logic [1:0]  record_format;
  logic [7:0]  output_capacity;
  srd_cfg_t    cfg_now;

  logic        in_take;
  logic        q_push;
  logic        q_pop;
  srd_entry_t  front_entry;
  srd_entry_t  q_head;
  srd_q_stat_t q_stat;

  // ---- configuration registers ----
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      record_format   <= '0;
      output_capacity <= CAPACITY_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        REG_RECORD_FORMAT:   record_format   <= cfg.reg_data[1:0];
        REG_OUTPUT_CAPACITY: output_capacity <= cfg.reg_data & BYTE_MASK;
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  always_comb begin
    cfg_now.wide     = record_format[0];
    cfg_now.rot      = record_format[1];
    cfg_now.capacity = output_capacity;
  end

  // ---- front end: accept and classify ----
  // stall input only when the queue cannot take a result
  assign payload.ready = !q_stat.full;
  assign in_take       = payload.valid && payload.ready;

  srd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg_now),
    .accept       (in_take),
    .data_byte    (payload.data_byte),
    .first_byte   (payload.first_byte),
    .last_byte    (payload.last_byte),
    .record_count (payload.record_count),
    .push         (q_push),
    .entry        (front_entry)
  );

  // ---- decoupling queue ----
  srd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (front_entry),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  // ---- back end: format and present ----
  srd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (q_head),
    .q_stat  (q_stat),
    .pop     (q_pop),
    .records (records)
  );

`ifndef SYNTHESIS
  // front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_stat.full))
    else $error("queue push while full");

  // every result is a record, an end of message, or both
  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    records.valid |-> (records.record_valid || records.message_done))
    else $error("empty result presented");

  // count is only reported on the end-of-message item
  a_decoded_zero: assert property (@(posedge clk) disable iff (rst)
    (records.valid && !records.message_done) |-> (records.records_decoded == 8'd0))
    else $error("records_decoded set without message_done");

  // an unconsumed result never vanishes
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (records.valid && !records.ready) |=> records.valid)
    else $error("result dropped while stalled");
`endif

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import srd_pkg::*;

  // One payload item as the sender offers it.
  typedef struct {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic [7:0] count;
  } payload_byte_t;

  // One item on the records channel.
  typedef struct {
    logic               record_valid;
    logic [7:0]         shape_tag;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        angle;
    logic signed [15:0] angular_rate;
    logic [7:0]         record_index;
    logic               message_done;
    logic [7:0]         records_decoded;
  } deframed_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Everything the bench drives sits in plain registers with known start values.
  logic       in_valid = 1'b0;
  logic [7:0] in_data  = 8'd0;
  logic       in_first = 1'b0;
  logic       in_last  = 1'b0;
  logic [7:0] in_count = 8'd0;
  logic       out_ready = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [1:0] cfg_index = 2'd0;
  logic [7:0] cfg_data  = 8'd0;

  srd_in_if  payload_if ();
  srd_out_if records_if ();
  srd_cfg_if cfg_if ();

  assign payload_if.valid        = in_valid;
  assign payload_if.data_byte    = in_data;
  assign payload_if.first_byte   = in_first;
  assign payload_if.last_byte    = in_last;
  assign payload_if.record_count = in_count;
  assign records_if.ready        = out_ready;
  assign cfg_if.valid            = cfg_valid;
  assign cfg_if.reg_index        = cfg_index;
  assign cfg_if.reg_data         = cfg_data;

  shape_record_deframer DUT (
    .clk     (clk),
    .rst     (rst),
    .payload (payload_if),
    .records (records_if),
    .cfg     (cfg_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Bench copy of the two registers.
  logic [1:0] fmt_sel;
  logic [7:0] capacity;

  // Bench copy of the deframer state.
  logic [3:0]  rec_pos;     // byte position inside the current record
  logic [7:0]  recs_out;    // records emitted in this message
  logic [7:0]  rec_limit;   // min(count, capacity) latched on the first byte
  logic [63:0] rec_bytes;   // record bytes 1..8, byte k at bits 8*(k-1)
  logic [7:0]  rec_id;      // record byte 0

  payload_byte_t bytes_to_send[$];
  deframed_t     expected_records[$];

  int  bytes_queued = 0;
  int  bytes_taken = 0;
  int  records_checked = 0;
  int  ends_checked = 0;
  int  settings_written = 0;
  int  errors = 0;
  bit  calm = 1'b0;          // last stretch: no idling on either side

  // Record byte k (1..8) of the record being assembled.
  function automatic logic [7:0] field_byte(int k);
    return rec_bytes[8*(k-1) +: 8];
  endfunction

  // Advance the bench model by one accepted payload item; queue what it yields.
  task automatic deframe_byte(input payload_byte_t b);
    logic      wide;
    logic      rot;
    int        stride;
    int        rofs;
    int        p;
    logic      emit;
    deframed_t r;
    wide   = fmt_sel[0];
    rot    = fmt_sel[1];
    stride = BASE_STRIDE + (wide ? WIDE_EXTRA : 0) + (rot ? ROT_EXTRA : 0);
    emit   = 1'b0;
    r = '{default: '0};

    // A first byte restarts everything, then is taken as record byte 0.
    if (b.first) begin
      rec_pos   = '0;
      recs_out  = '0;
      rec_bytes = '0;
      rec_limit = (b.count < capacity) ? b.count : capacity;
    end

    p = rec_pos;
    if (p == 0) begin
      rec_id    = b.data;
      rec_bytes = '0;
    end else if (p <= 8) begin
      rec_bytes[8*(p-1) +: 8] = b.data;
    end

    // Record boundary uses the stride of the format in force right now.
    if (p + 1 >= stride) begin
      rec_pos = '0;
      if (recs_out < rec_limit) begin
        emit           = 1'b1;
        rofs           = wide ? 5 : 3;
        r.record_valid = 1'b1;
        r.shape_tag    = rec_id;
        if (wide) begin
          r.pos_x = {field_byte(2), field_byte(1)};
          r.pos_y = {field_byte(4), field_byte(3)};
        end else begin
          r.pos_x = sext8(field_byte(1));
          r.pos_y = sext8(field_byte(2));
        end
        if (rot) begin
          r.angle        = {field_byte(rofs + 1), field_byte(rofs)};
          r.angular_rate = {field_byte(rofs + 3), field_byte(rofs + 2)};
        end
        r.record_index = recs_out;
        recs_out       = recs_out + 8'd1;
      end
    end else begin
      rec_pos = rec_pos + 4'd1;
    end

    // Last byte reports the count and closes the message.
    if (b.last) begin
      r.message_done    = 1'b1;
      r.records_decoded = recs_out;
      rec_pos   = '0;
      recs_out  = '0;
      rec_limit = '0;
    end

    if (emit || b.last) expected_records.push_back(r);
  endtask

  // Sender: holds the item until taken, then maybe idles a burst.
  int gap_left;
  bit send_jitter;
  always @(posedge clk) begin
    payload_byte_t nb;
    if (rst) begin
      in_valid    <= 1'b0;
      gap_left    = 0;
      send_jitter = 1'b1;
      rec_pos     = '0;
      recs_out    = '0;
      rec_limit   = '0;
    end else begin
      if (in_valid && payload_if.ready) begin
        deframe_byte('{data: payload_if.data_byte, first: payload_if.first_byte,
                       last: payload_if.last_byte, count: payload_if.record_count});
        bytes_taken++;
      end
      if ($urandom_range(0, 99) == 0) send_jitter = !send_jitter;
      if (!in_valid || payload_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (bytes_to_send.size() > 0) begin
          nb = bytes_to_send.pop_front();
          in_data  <= nb.data;
          in_first <= nb.first;
          in_last  <= nb.last;
          in_count <= nb.count;
          in_valid <= 1'b1;
          if (!calm && send_jitter && $urandom_range(0, 5) == 0)
            gap_left = $urandom_range(1, 12);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready: random stall bursts, plus a long hold-off now and then
  // so the internal queue fills and payload ready has to drop.
  int stall_left;
  int hold_left;
  int hold_mark;
  bit recv_jitter;
  always @(posedge clk) begin
    if (rst) begin
      out_ready   <= 1'b0;
      stall_left  = 0;
      hold_left   = 0;
      hold_mark   = 250;
      recv_jitter = 1'b1;
    end else begin
      if ($urandom_range(0, 99) == 0) recv_jitter = !recv_jitter;
      if (!calm && hold_left == 0 && bytes_taken >= hold_mark) begin
        hold_left = 80;
        hold_mark += 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && recv_jitter && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 11);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Checker: every taken record item against the oldest expectation.
  always @(posedge clk) begin
    deframed_t want;
    if (!rst && records_if.valid && records_if.ready) begin
      if (expected_records.size() == 0) begin
        $display("%0t ns: unexpected item, got record_valid %h shape_tag %h done %h",
                 $time, records_if.record_valid, records_if.shape_tag,
                 records_if.message_done);
        errors++;
      end else begin
        want = expected_records.pop_front();
        check_field("record_valid", want.record_valid, records_if.record_valid);
        check_field("shape_tag", want.shape_tag, records_if.shape_tag);
        check_field("pos_x", want.pos_x, records_if.pos_x);
        check_field("pos_y", want.pos_y, records_if.pos_y);
        check_field("angle", want.angle, records_if.angle);
        check_field("angular_rate", want.angular_rate, records_if.angular_rate);
        check_field("record_index", want.record_index, records_if.record_index);
        check_field("message_done", want.message_done, records_if.message_done);
        check_field("records_decoded", want.records_decoded,
                    records_if.records_decoded);
        if (want.record_valid) records_checked++;
        if (want.message_done) ends_checked++;
      end
    end
  end

  // Register copy follows every accepted write.
  always @(posedge clk) begin
    if (rst) begin
      fmt_sel  = 2'd0;
      capacity = CAPACITY_RESET;
    end else if (cfg_valid && cfg_if.ready) begin
      settings_written++;
      case (cfg_if.reg_index)
        REG_RECORD_FORMAT:   fmt_sel  = cfg_if.reg_data[1:0];
        REG_OUTPUT_CAPACITY: capacity = cfg_if.reg_data;
        default: ;
      endcase
    end
  end

  task automatic push_byte(input logic [7:0] data, input logic first,
                           input logic last, input logic [7:0] count);
    bytes_to_send.push_back('{data: data, first: first, last: last, count: count});
    bytes_queued++;
  endtask

  // One message at the current stride: mostly clean, with some stray bytes,
  // missing last bytes and restarts mixed in.
  task automatic queue_message();
    int         stride;
    int         n_rec;
    int         n_bytes;
    int         kind;
    int         restart_at;
    logic [7:0] claim;
    stride = BASE_STRIDE + (fmt_sel[0] ? WIDE_EXTRA : 0) + (fmt_sel[1] ? ROT_EXTRA : 0);
    n_rec  = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 4);
    n_bytes = n_rec * stride;
    if ($urandom_range(0, 3) == 0) n_bytes += $urandom_range(1, stride - 1);
    if (n_bytes == 0) n_bytes = 1;
    case ($urandom_range(0, 7))
      0: claim = 8'($urandom);
      1: claim = 8'd0;
      2: claim = 8'd255;
      3: claim = (n_rec > 0) ? 8'(n_rec - 1) : 8'd0;
      default: claim = 8'(n_rec + $urandom_range(0, 2));
    endcase
    kind = $urandom_range(0, 19);   // 0 stray bytes, 1 no last byte, 2 restart
    restart_at = (kind == 2) ? $urandom_range(0, n_bytes - 1) : -1;
    for (int i = 0; i < n_bytes; i++)
      push_byte(8'($urandom),
                (kind != 0 && i == 0) || i == restart_at,
                kind != 1 && i == n_bytes - 1,
                (i == 0 || i == restart_at) ? claim : 8'($urandom));
  endtask

  task automatic write_register(input cfg_reg_t idx, input logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_valid <= 1'b0;
  endtask

  // Drain: nothing left to send, nothing expected, then a wait so that
  // bytes that produce no item clear the pipeline.
  task automatic wait_idle();
    while (bytes_to_send.size() > 0 || in_valid || expected_records.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  logic [1:0] fmt_plan [8] = '{2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd3, 2'd1, 2'd0};
  logic [7:0] cap_plan [8];

  initial begin
    int phase_start;
    cap_plan = '{8'd255, 8'd3, 8'd0, 8'd1, 8'd255, 8'($urandom_range(2, 9)),
                 8'($urandom), 8'd255};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset format: narrow, no rotation, stride 3.
    push_byte(8'h55, 1'b0, 1'b0, 8'h00);     // stray byte before any message
    push_byte(8'hAA, 1'b0, 1'b1, 8'hFF);     // stray last byte reports zero
    push_byte(8'hFF, 1'b1, 1'b1, 8'hFF);     // one-byte message
    // count 2: two records out, third over the limit, trailing partial byte
    push_byte(8'hFF, 1'b1, 1'b0, 8'd2);
    push_byte(8'h80, 1'b0, 1'b0, 8'h00);
    push_byte(8'h7F, 1'b0, 1'b0, 8'hFF);
    push_byte(8'h00, 1'b0, 1'b0, 8'h00);
    push_byte(8'hFF, 1'b0, 1'b0, 8'h00);
    push_byte(8'h01, 1'b0, 1'b0, 8'h00);
    push_byte(8'h12, 1'b0, 1'b0, 8'h00);
    push_byte(8'h34, 1'b0, 1'b0, 8'h00);
    push_byte(8'h56, 1'b0, 1'b0, 8'h00);
    push_byte(8'h9A, 1'b0, 1'b1, 8'h00);
    // zero count: nothing emitted
    push_byte(8'h01, 1'b1, 1'b0, 8'd0);
    push_byte(8'h02, 1'b0, 1'b0, 8'h00);
    push_byte(8'h03, 1'b0, 1'b1, 8'h00);
    // message left open across a format change
    push_byte(8'h44, 1'b1, 1'b0, 8'd255);
    push_byte(8'hC0, 1'b0, 1'b0, 8'h00);
    push_byte(8'h3F, 1'b0, 1'b0, 8'h00);
    push_byte(8'h77, 1'b0, 1'b0, 8'h00);
    wait_idle();
    write_register(REG_RECORD_FORMAT, 8'h03);
    // rest of that record now at stride 9: wide x/y, angle and rate
    push_byte(8'hFF, 1'b0, 1'b0, 8'h00);
    push_byte(8'h7F, 1'b0, 1'b0, 8'h00);
    push_byte(8'h00, 1'b0, 1'b0, 8'h00);
    push_byte(8'h80, 1'b0, 1'b0, 8'h00);
    push_byte(8'hFF, 1'b0, 1'b0, 8'h00);
    push_byte(8'hFF, 1'b0, 1'b0, 8'h00);
    push_byte(8'h01, 1'b0, 1'b0, 8'h00);
    push_byte(8'h80, 1'b0, 1'b1, 8'h00);
    wait_idle();

    // Random part: one format and capacity setting per phase, the last one with no idling.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) calm = 1'b1;
      write_register(REG_RECORD_FORMAT, (8'($urandom) & 8'hFC) | {6'd0, fmt_plan[ph]});
      write_register(REG_OUTPUT_CAPACITY, cap_plan[ph]);
      phase_start = bytes_queued;
      while (bytes_queued - phase_start < 190) queue_message();
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (expected_records.size() > 0) begin
      $display("%0d expected items never arrived", expected_records.size());
      errors++;
    end
    $display("Sent %0d payload items under %0d register writes;", bytes_taken,
             settings_written);
    $display("checked %0d records and %0d message ends.", records_checked,
             ends_checked);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #1000000;
    $display("Timeout with %0d items still expected", expected_records.size());
    $display("Verification failed");
    $finish;
  end

endmodule
